FILE: hdl/bbc_pkg.sv
`default_nettype none

package bbc_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned DIGITS  = 16;
  localparam int unsigned ACC_W   = 80;

  localparam logic KIND_TO_BCD = 1'b0;
  localparam logic KIND_TO_BIN = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_BAD_DIGIT = 2'd2;

  typedef struct packed {
    logic               kind;
    logic               wide;
    logic               bad;
    logic [ACC_W-1:0]   acc;
    logic [VALUE_W-1:0] src;
  } stage_t;

  // One double-dabble step: correct every digit, then shift in one binary bit.
  function automatic logic [ACC_W-1:0] dd_step(input logic [ACC_W-1:0] acc, input logic b);
    logic [ACC_W-1:0] adj;
    adj = acc;
    for (int n = 0; n < ACC_W / 4; n++) begin
      if (acc[4*n +: 4] >= 4'd5) begin
        adj[4*n +: 4] = acc[4*n +: 4] + 4'd3;
      end
    end
    return {adj[ACC_W-2:0], b};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/bbc_if.sv
`default_nettype none

interface bbc_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface bbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result;
  logic [1:0]  status;

  modport source (output valid, output result, output status, input ready);
  modport sink   (input valid, input result, input status, output ready);
endinterface

`default_nettype wire

FILE: hdl/bbc_cell.sv
`default_nettype none

module bbc_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            valid_i,
  output logic            ready_o,
  input  bbc_pkg::stage_t stage_i,
  output logic            valid_o,
  input  logic            ready_i,
  output bbc_pkg::stage_t stage_o
);
  import bbc_pkg::*;

  logic               valid_r;
  stage_t             stage_r;
  stage_t             stage_nxt;
  logic               load;
  logic [ACC_W-1:0]   acc;
  logic [VALUE_W-1:0] src;
  logic [3:0]         digit;
  logic [VALUE_W-1:0] acc64;

  assign ready_o = ~valid_r | ready_i;
  assign load    = valid_i & ready_o;
  assign digit   = stage_i.src[VALUE_W-1 -: 4];
  assign acc64   = stage_i.acc[VALUE_W-1:0];

  always_comb begin
    stage_nxt = stage_i;
    acc       = stage_i.acc;
    src       = stage_i.src;
    if (stage_i.kind == KIND_TO_BCD) begin
      for (int j = 0; j < 4; j++) begin
        acc = dd_step(acc, src[VALUE_W-1]);
        src = {src[VALUE_W-2:0], 1'b0};
      end
    end else begin
      // Horner step: acc * 10 + next digit, most significant digit first
      acc = {{(ACC_W-VALUE_W){1'b0}},
             (acc64 << 3) + (acc64 << 1) + {{(VALUE_W-4){1'b0}}, digit}};
      src = {src[VALUE_W-5:0], 4'd0};
      stage_nxt.bad = stage_i.bad | (digit > 4'd9);
    end
    stage_nxt.acc = acc;
    stage_nxt.src = src;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_r <= stage_nxt;
    end
  end

  assign valid_o = valid_r;
  assign stage_o = stage_r;

endmodule

`default_nettype wire

FILE: hdl/bbc_out.sv
`default_nettype none

module bbc_out (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            valid_i,
  output logic            ready_o,
  input  bbc_pkg::stage_t stage_i,
  bbc_out_if.source       out_ch
);
  import bbc_pkg::*;

  logic               valid_r;
  logic [VALUE_W-1:0] result_r;
  logic [1:0]         status_r;
  logic [VALUE_W-1:0] result_nxt;
  logic [1:0]         status_nxt;
  logic               overflow;
  logic               load;

  assign ready_o = ~valid_r | out_ch.ready;
  assign load    = valid_i & ready_o;

  assign overflow = stage_i.wide ? (|stage_i.acc[ACC_W-1:VALUE_W])
                                 : (|stage_i.acc[ACC_W-1:VALUE_W/2]);

  always_comb begin
    result_nxt = stage_i.acc[VALUE_W-1:0];
    if (!stage_i.wide) begin
      result_nxt[VALUE_W-1:VALUE_W/2] = '0;
    end
    if (stage_i.kind == KIND_TO_BCD) begin
      status_nxt = overflow ? STATUS_OVERFLOW : STATUS_OK;
    end else begin
      status_nxt = stage_i.bad ? STATUS_BAD_DIGIT : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid  = valid_r;
  assign out_ch.result = result_r;
  assign out_ch.status = status_r;

endmodule

`default_nettype wire

FILE: hdl/bcd_binary_converter_top.sv
// BCD / binary converter.
// in_ch  : one transfer per item: kind (0 binary to packed BCD, 1 packed BCD
//          to binary) and a 64-bit operand.
// out_ch : one transfer per item: result and status (0 ok, 1 too many decimal
//          digits, 2 BCD digit above nine), in input order.
// APB    : register 0 at address 0, wide_integers (1 = 64-bit, 0 = 32-bit;
//          32-bit mode uses and returns the low 32 bits only). pready is tied
//          high; write it only while no item is in flight.
// Stages : 16 cells, each handling four binary bits or one BCD digit, plus the
//          output register; the first cell loads at the input transfer.
//          Throughput: one item per cycle unless out_ch back-pressure has
//          filled every stage (see Stall).
// Stall  : each cell is ready when empty or when its successor moves, so
//          bubbles collapse and in_ch.ready stays high until all 17 stages
//          hold items while out_ch.ready is low.
// Reset  : synchronous, active low; empties the pipeline and sets
//          wide_integers to 1.
`default_nettype none

module bcd_binary_converter_top (
  input  logic        clk,
  input  logic        rst_n,
  bbc_in_if.sink      in_ch,
  bbc_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bbc_pkg::*;

  localparam logic REG_WIDE = 1'b0;

  logic   wide_r;
  logic   reg_wr;
  stage_t stage   [DIGITS+1];
  logic   valid   [DIGITS+1];
  logic   ready   [DIGITS+1];

  assign pready = 1'b1;
  assign reg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_WIDE);
  assign prdata = (paddr[2] == REG_WIDE) ? {31'd0, wide_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r <= 1'b1;
    end else if (reg_wr) begin
      wide_r <= pwdata[0];
    end
  end

  always_comb begin
    stage[0].kind = in_ch.kind;
    stage[0].wide = wide_r;
    stage[0].bad  = 1'b0;
    stage[0].acc  = '0;
    stage[0].src  = wide_r ? in_ch.value : {32'd0, in_ch.value[31:0]};
  end

  assign valid[0]    = in_ch.valid;
  assign in_ch.ready = ready[0];

  for (genvar k = 0; k < DIGITS; k++) begin : g_cell
    bbc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (valid[k]),
      .ready_o (ready[k]),
      .stage_i (stage[k]),
      .valid_o (valid[k+1]),
      .ready_i (ready[k+1]),
      .stage_o (stage[k+1])
    );
  end

  bbc_out u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (valid[DIGITS]),
    .ready_o (ready[DIGITS]),
    .stage_i (stage[DIGITS]),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

FILE: hdl/bbc_checker.sv
`default_nettype none

module bbc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_result,
  input logic [1:0]  out_status
);
  import bbc_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_OK || out_status == STATUS_OVERFLOW ||
                   out_status == STATUS_BAD_DIGIT))
    else $error("undefined status code");

  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is drained");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind bcd_binary_converter_top bbc_checker u_bbc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_result (out_ch.result),
  .out_status (out_ch.status)
);

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps

import bbc_pkg::*;

class conv_scoreboard;
  typedef struct {
    logic [63:0] result;
    logic [1:0]  status;
  } conv_t;

  bit    wide = 1'b1;
  conv_t expected_q[$];
  int    errors;

  function automatic conv_t predict_conversion(logic kind, logic [63:0] value);
    conv_t       c;
    logic [63:0] mask;
    logic [63:0] v;
    logic [63:0] acc;
    logic [63:0] weight;
    logic [63:0] d;
    int          n;
    mask   = wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
    n      = wide ? 16 : 8;
    v      = value & mask;
    acc    = '0;
    weight = 64'd1;
    c.status = STATUS_OK;
    if (kind == KIND_TO_BCD) begin
      for (int i = 0; i < n; i++) begin
        d = v % 64'd10;
        acc[4*i +: 4] = d[3:0];
        v = v / 64'd10;
      end
      if (v != 0) c.status = STATUS_OVERFLOW;
    end else begin
      for (int i = 0; i < n; i++) begin
        d = (v >> (4 * i)) & 64'hF;
        if (d > 64'd9) c.status = STATUS_BAD_DIGIT;
        acc = acc + d * weight;
        weight = weight * 64'd10;
      end
    end
    c.result = acc & mask;
    return c;
  endfunction

  function void note_input(logic kind, logic [63:0] value);
    expected_q.push_back(predict_conversion(kind, value));
  endfunction

  function void check_result(logic [63:0] result, logic [1:0] status);
    conv_t e;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result transfer result=%h status=%0d", $time, result, status);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (result !== e.result) begin
      $display("%0t: result mismatch expected %h actual %h", $time, e.result, result);
      errors++;
    end
    if (status !== e.status) begin
      $display("%0t: status mismatch expected %0d actual %0d", $time, e.status, status);
      errors++;
    end
  endfunction

  function int outstanding();
    return expected_q.size();
  endfunction
endclass

module testbench;
  localparam logic [2:0] ADDR_WIDE   = 3'd0;
  localparam logic [2:0] ADDR_UNUSED = 3'd4;
  localparam int         IDLE_LIMIT  = 4000;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bbc_in_if  in_ch ();
  bbc_out_if out_ch ();

  bcd_binary_converter_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  conv_scoreboard sb;
  bit             idle_on;
  int             ready_hold;
  int             quiet_cycles;
  int             cfg_errors;

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b1;
      ready_hold   <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!idle_on || $urandom_range(0, 1) == 0) begin
      out_ch.ready <= 1'b1;
      ready_hold   <= $urandom_range(0, 7);
    end else begin
      out_ch.ready <= 1'b0;
      ready_hold   <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_input(in_ch.kind, in_ch.value);
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.result, out_ch.status);
  end

  always @(posedge clk) begin
    if (!rst_n || psel || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_item(logic kind, logic [63:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_WIDE) sb.wide = data[0];
  endtask

  task automatic check_width_reg();
    logic [31:0] d;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_WIDE;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    d = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (d !== {31'b0, sb.wide}) begin
      $display("%0t: width register readback expected %h actual %h", $time,
               {31'b0, sb.wide}, d);
      cfg_errors++;
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [63:0] pow10(int k);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < k; i++) p = p * 64'd10;
    return p;
  endfunction

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    int          r;
    int          nd;
    r = $urandom_range(0, 9);
    v = {$urandom, $urandom};
    case (r)
      0, 1: ;
      2: v = 64'($urandom_range(0, 1000));
      3, 4: v = v >> $urandom_range(0, 63);
      5, 6, 7, 8: begin
        nd = $urandom_range(1, 16);
        v  = '0;
        for (int i = 0; i < nd; i++) v[4*i +: 4] = 4'($urandom_range(0, 9));
        if (r == 8) v[4*$urandom_range(0, 15) +: 4] = 4'($urandom_range(10, 15));
      end
      default: begin
        v = pow10($urandom_range(0, 19));
        if ($urandom_range(0, 1)) v = v - 64'd1;
      end
    endcase
    return v;
  endfunction

  task automatic run_directed();
    if (sb.wide) begin
      push_item(KIND_TO_BCD, 64'd0);
      push_item(KIND_TO_BCD, 64'd1);
      push_item(KIND_TO_BCD, 64'hFFFF_FFFF_FFFF_FFFF);
      push_item(KIND_TO_BCD, 64'd9999999999999999);
      push_item(KIND_TO_BCD, 64'd10000000000000000);
      push_item(KIND_TO_BIN, 64'd0);
      push_item(KIND_TO_BIN, 64'h9999_9999_9999_9999);
      push_item(KIND_TO_BIN, 64'hFFFF_FFFF_FFFF_FFFF);
      push_item(KIND_TO_BIN, 64'hA000_0000_0000_0000);
      push_item(KIND_TO_BIN, 64'h0000_0000_0000_000A);
      push_item(KIND_TO_BIN, 64'h1234_5678_9012_3456);
    end else begin
      push_item(KIND_TO_BCD, 64'd99999999);
      push_item(KIND_TO_BCD, 64'd100000000);
      push_item(KIND_TO_BCD, 64'hFFFF_FFFF_0000_0000);
      push_item(KIND_TO_BCD, 64'hFFFF_FFFF_FFFF_FFFF);
      push_item(KIND_TO_BIN, 64'hFFFF_FFFF_9999_9999);
      push_item(KIND_TO_BIN, 64'h0000_0000_F000_0000);
      push_item(KIND_TO_BIN, 64'hFFFF_FFFF_FFFF_FFFF);
    end
  endtask

  task automatic run_phase(logic [31:0] width_word, int count);
    wait_drained();
    apb_write(ADDR_WIDE, width_word);
    check_width_reg();
    run_directed();
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) idle_on = ($urandom_range(0, 4) != 0);
      push_item(1'($urandom_range(0, 1)), random_value());
    end
    idle_on = 1'b1;
  endtask

  initial begin
    sb           = new();
    idle_on      = 1'b1;
    cfg_errors   = 0;
    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = KIND_TO_BCD;
    in_ch.value  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset value, then a write outside the register map must leave it alone
    check_width_reg();
    apb_write(ADDR_UNUSED, 32'h0000_0000);
    check_width_reg();
    run_directed();
    for (int i = 0; i < 450; i++) push_item(1'($urandom_range(0, 1)), random_value());

    run_phase(32'hA5A5_A5A4, 480);
    run_phase(32'h0000_0001, 450);
    run_phase(32'h0000_0000, 400);

    wait_drained();
    if (sb.errors == 0 && cfg_errors == 0 && sb.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

FILE: sim.f
hdl/bbc_pkg.sv
hdl/bbc_if.sv
hdl/bbc_cell.sv
hdl/bbc_out.sv
hdl/bcd_binary_converter_top.sv
hdl/bbc_checker.sv
bench/testbench.sv
